@@ hdl/pimap_pkg.sv @@
// Shared widths, register indexes and control types for the perspective
// inverse pixel map. No dependencies.
package pimap_pkg;

    localparam int PIX_W     = 17;
    localparam int COEF_W    = 48;
    localparam int DIM_W     = 16;
    localparam int PROD_W    = COEF_W + PIX_W + 1;
    localparam int SUM_W     = 67;
    localparam int MAG_W     = SUM_W;
    localparam int SRC_FRAC  = 8;
    localparam int UV_FRAC   = 16;
    localparam int SCL_W     = DIM_W + SRC_FRAC;
    localparam int NUM_W     = 91;
    localparam int Q_W       = 33;
    localparam int REM_W     = MAG_W + Q_W + 1;
    localparam int LANES     = 4;
    localparam int CHUNK_W   = 23;
    localparam int CHUNKS    = 3;
    localparam int PPROD_W   = CHUNK_W + SCL_W;
    localparam int OUT_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam int LN_U  = 0;
    localparam int LN_V  = 1;
    localparam int LN_SX = 2;
    localparam int LN_SY = 3;

    localparam logic [CFG_IDX_W-1:0] REG_U_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_U_STEP_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_V_BASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_V_STEP_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_V_STEP_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_D_BASE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_D_STEP_X = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_DIMS = 3'd7;

    typedef struct packed {
        logic [COEF_W-1:0] a0;
        logic [COEF_W-1:0] a1;
        logic [COEF_W-1:0] b0;
        logic [COEF_W-1:0] b1;
        logic [COEF_W-1:0] b2;
        logic [COEF_W-1:0] c0;
        logic [COEF_W-1:0] c1;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
    } t_coef;

    typedef struct packed {
        logic             zero;
        logic             in_range;
        logic [LANES-1:0] neg;
    } t_side;

    typedef logic [NUM_W-1:0] t_num;
    typedef logic [MAG_W-1:0] t_mag;
    typedef logic [Q_W-1:0]   t_quo;

endpackage

@@ hdl/pimap_affine.sv @@
// Front end of the pixel map: projective numerators and depth, magnitudes,
// range flags and source-size scaling, five register stages. Uses pimap_pkg.
module pimap_affine
    import pimap_pkg::*;
#(
    parameter int PIXEL_FRAC_BITS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_px,
    input  logic [PIX_W-1:0] i_py,
    input  t_coef            i_coef,
    output logic             o_valid,
    output t_num             o_num [LANES],
    output t_mag             o_den,
    output t_side            o_side
);

    logic                     r1_v;
    logic signed [PROD_W-1:0] r1_pu, r1_pv1, r1_pv2, r1_pw;

    logic                    r2_v;
    logic signed [SUM_W-1:0] r2_nu, r2_nv, r2_w;
    logic signed [SUM_W-1:0] n2_nu, n2_nv, n2_w;
    logic signed [SUM_W-1:0] base_u, base_v, base_w;

    logic       r3_v;
    t_mag       r3_mu, r3_mv, r3_mw;
    logic       r3_su, r3_sv, r3_sw, r3_nuz, r3_nvz, r3_wz;

    logic                r4_v;
    t_side               r4_side;
    t_mag                r4_mw;
    t_num                r4_nu16, r4_nv16;
    logic [PPROD_W-1:0]  r4_ppx [CHUNKS];
    logic [PPROD_W-1:0]  r4_ppy [CHUNKS];
    logic [CHUNKS*CHUNK_W-1:0] ext_u, ext_v;
    logic [SCL_W-1:0]    scale_x, scale_y;
    t_side               n4_side;

    logic                r5_v;
    t_num                r5_num [LANES];
    t_mag                r5_den;
    t_side               r5_side;
    t_num                n5_sx, n5_sy;

    // stage 1: coefficient times pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pu  <= $signed(i_coef.a1) * $signed({1'b0, i_px});
            r1_pv1 <= $signed(i_coef.b1) * $signed({1'b0, i_px});
            r1_pv2 <= $signed(i_coef.b2) * $signed({1'b0, i_py});
            r1_pw  <= $signed(i_coef.c1) * $signed({1'b0, i_px});
        end
    end

    // stage 2: add aligned base terms
    assign base_u = SUM_W'($signed(i_coef.a0)) <<< PIXEL_FRAC_BITS;
    assign base_v = SUM_W'($signed(i_coef.b0)) <<< PIXEL_FRAC_BITS;
    assign base_w = SUM_W'($signed(i_coef.c0)) <<< PIXEL_FRAC_BITS;
    assign n2_nu  = base_u + SUM_W'(r1_pu);
    assign n2_nv  = base_v + SUM_W'(r1_pv1) + SUM_W'(r1_pv2);
    assign n2_w   = base_w + SUM_W'(r1_pw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_nu <= n2_nu;
            r2_nv <= n2_nv;
            r2_w  <= n2_w;
        end
    end

    // stage 3: sign and magnitude
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_su  <= r2_nu[SUM_W-1];
            r3_sv  <= r2_nv[SUM_W-1];
            r3_sw  <= r2_w[SUM_W-1];
            r3_mu  <= r2_nu[SUM_W-1] ? MAG_W'(-r2_nu) : MAG_W'(r2_nu);
            r3_mv  <= r2_nv[SUM_W-1] ? MAG_W'(-r2_nv) : MAG_W'(r2_nv);
            r3_mw  <= r2_w[SUM_W-1]  ? MAG_W'(-r2_w)  : MAG_W'(r2_w);
            r3_nuz <= (r2_nu == '0);
            r3_nvz <= (r2_nv == '0);
            r3_wz  <= (r2_w == '0);
        end
    end

    // stage 4: range flags and partial products of the source scaling
    assign ext_u   = (CHUNKS*CHUNK_W)'(r3_mu);
    assign ext_v   = (CHUNKS*CHUNK_W)'(r3_mv);
    assign scale_x = {i_coef.width, {SRC_FRAC{1'b0}}};
    assign scale_y = {i_coef.height, {SRC_FRAC{1'b0}}};

    always_comb begin
        n4_side.zero     = r3_wz || (i_coef.width == '0) || (i_coef.height == '0);
        n4_side.in_range = (r3_nuz || (r3_su == r3_sw)) && (r3_mu <= r3_mw) &&
                           (r3_nvz || (r3_sv == r3_sw)) && (r3_mv <= r3_mw);
        n4_side.neg[LN_U]  = r3_su ^ r3_sw;
        n4_side.neg[LN_V]  = r3_sv ^ r3_sw;
        n4_side.neg[LN_SX] = r3_su ^ r3_sw;
        n4_side.neg[LN_SY] = r3_sv ^ r3_sw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_side <= n4_side;
            r4_mw   <= r3_mw;
            r4_nu16 <= NUM_W'(r3_mu) << UV_FRAC;
            r4_nv16 <= NUM_W'(r3_mv) << UV_FRAC;
            for (int k = 0; k < CHUNKS; k++) begin
                r4_ppx[k] <= ext_u[k*CHUNK_W +: CHUNK_W] * scale_x;
                r4_ppy[k] <= ext_v[k*CHUNK_W +: CHUNK_W] * scale_y;
            end
        end
    end

    // stage 5: combine partial products
    always_comb begin
        n5_sx = '0;
        n5_sy = '0;
        for (int k = 0; k < CHUNKS; k++) begin
            n5_sx = n5_sx + (NUM_W'(r4_ppx[k]) << (k*CHUNK_W));
            n5_sy = n5_sy + (NUM_W'(r4_ppy[k]) << (k*CHUNK_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (i_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_num[LN_U]  <= r4_nu16;
            r5_num[LN_V]  <= r4_nv16;
            r5_num[LN_SX] <= n5_sx;
            r5_num[LN_SY] <= n5_sy;
            r5_den        <= r4_mw;
            r5_side       <= r4_side;
        end
    end

    assign o_valid = r5_v;
    assign o_num   = r5_num;
    assign o_den   = r5_den;
    assign o_side  = r5_side;

endmodule

@@ hdl/pimap_div.sv @@
// Pipelined restoring divider, four lanes sharing one divisor, one quotient
// bit per stage plus an overflow check stage. Uses pimap_pkg.
module pimap_div
    import pimap_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_num  i_num [LANES],
    input  t_mag  i_den,
    input  t_side i_side,
    output logic  o_valid,
    output t_quo  o_quo [LANES],
    output logic  o_ovf [LANES],
    output t_side o_side
);

    logic  r_v    [0:Q_W];
    t_mag  r_d    [0:Q_W];
    t_side r_side [0:Q_W];
    t_num  r_rem  [0:Q_W][LANES];
    t_quo  r_q    [0:Q_W][LANES];
    logic  r_ovf  [0:Q_W][LANES];

    // stage 0: load, flag quotients that do not fit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0]    <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_load
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[0][l] <= i_num[l];
                r_q[0][l]   <= '0;
                r_ovf[0][l] <= (REM_W'({i_den, {Q_W{1'b0}}}) <= REM_W'(i_num[l]));
            end
        end
    end

    for (genvar s = 1; s <= Q_W; s++) begin : g_stage
        localparam int BIT = Q_W - s;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[s]    <= r_d[s-1];
                r_side[s] <= r_side[s-1];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [REM_W-1:0] w_trial;
            logic [REM_W-1:0] w_rem;
            logic             w_ge;

            assign w_trial = REM_W'(r_d[s-1]) << BIT;
            assign w_rem   = REM_W'(r_rem[s-1][l]);
            assign w_ge    = (w_rem >= w_trial);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s][l] <= w_ge ? NUM_W'(w_rem - w_trial) : r_rem[s-1][l];
                    r_q[s][l]   <= r_q[s-1][l] | (Q_W'(w_ge) << BIT);
                    r_ovf[s][l] <= r_ovf[s-1][l];
                end
            end
        end
    end

    assign o_valid = r_v[Q_W];
    assign o_side  = r_side[Q_W];

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_quo[l] = r_q[Q_W][l];
        assign o_ovf[l] = r_ovf[Q_W][l];
    end

endmodule

@@ hdl/perspective_inverse_pixel_map.sv @@
// Top level of the perspective inverse pixel map: configuration registers,
// pipeline control and the saturating output stage. Uses pimap_pkg,
// pimap_affine and pimap_div.
//
// Takes one display pixel per clock and returns its reference-image
// coordinates u, v (Q16.16) and source position (Q24.8), saturated, with a
// sample-valid flag. Five stages form the projective sums and scaled
// numerators, 34 stages of the shared-divisor divider (an overflow check,
// then one quotient bit each) produce the quotients, and one output register
// holds the beat. The whole pipeline advances together, so while a result is
// held by a stall no new pixel is taken. The user must write coefficients
// only while idle; the block itself does not enforce this.
module perspective_inverse_pixel_map
    import pimap_pkg::*;
#(
    parameter int PIXEL_FRAC_BITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PIX_W-1:0]     i_pixel_x,
    input  logic [PIX_W-1:0]     i_pixel_y,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [OUT_W-1:0]     o_u_coord,
    output logic [OUT_W-1:0]     o_v_coord,
    output logic [OUT_W-1:0]     o_source_x,
    output logic [OUT_W-1:0]     o_source_y,
    output logic                 o_sample_valid
);

    t_coef r_coef;
    logic  en;

    logic  aff_v;
    t_num  aff_num [LANES];
    t_mag  aff_den;
    t_side aff_side;

    logic  div_v;
    t_quo  div_quo [LANES];
    logic  div_ovf [LANES];
    t_side div_side;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_coord [LANES];
    logic              r_sample_valid;
    logic [OUT_W-1:0]  n_coord [LANES];

    function automatic logic [OUT_W-1:0] sat_q(input t_quo q, input logic ovf,
                                               input logic neg);
        logic [OUT_W-1:0] res;
        if (!ovf && q == '0) begin
            res = '0;
        end else if (!neg) begin
            res = (ovf || q > Q_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : q[OUT_W-1:0];
        end else begin
            res = (ovf || q > Q_W'(33'h0_8000_0000)) ? 32'h8000_0000
                                                     : OUT_W'(-q);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_U_BASE:   r_coef.a0 <= i_cfg_data;
                REG_U_STEP_X: r_coef.a1 <= i_cfg_data;
                REG_V_BASE:   r_coef.b0 <= i_cfg_data;
                REG_V_STEP_X: r_coef.b1 <= i_cfg_data;
                REG_V_STEP_Y: r_coef.b2 <= i_cfg_data;
                REG_D_BASE:   r_coef.c0 <= i_cfg_data;
                REG_D_STEP_X: r_coef.c1 <= i_cfg_data;
                REG_SRC_DIMS: begin
                    r_coef.width  <= i_cfg_data[DIM_W-1:0];
                    r_coef.height <= i_cfg_data[2*DIM_W-1:DIM_W];
                end
            endcase
        end
    end

    // advance everything unless a held result is stalled
    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    pimap_affine #(
        .PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)
    ) u_affine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_px    (i_pixel_x),
        .i_py    (i_pixel_y),
        .i_coef  (r_coef),
        .o_valid (aff_v),
        .o_num   (aff_num),
        .o_den   (aff_den),
        .o_side  (aff_side)
    );

    pimap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (aff_v),
        .i_num   (aff_num),
        .i_den   (aff_den),
        .i_side  (aff_side),
        .o_valid (div_v),
        .o_quo   (div_quo),
        .o_ovf   (div_ovf),
        .o_side  (div_side)
    );

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_coord[l] = div_side.zero ? '0
                                       : sat_q(div_quo[l], div_ovf[l], div_side.neg[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_coord        <= n_coord;
            r_sample_valid <= !div_side.zero && div_side.in_range;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_u_coord      = r_coord[LN_U];
    assign o_v_coord      = r_coord[LN_V];
    assign o_source_x     = r_coord[LN_SX];
    assign o_source_y     = r_coord[LN_SY];
    assign o_sample_valid = r_sample_valid;

`ifndef SYNTH
    a_u_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sample_valid) |-> (o_u_coord <= 32'h0001_0000))
        else $error("u out of unit range on valid sample");

    a_v_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sample_valid) |-> (o_v_coord <= 32'h0001_0000))
        else $error("v out of unit range on valid sample");

    a_src_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sample_valid) |-> (!o_source_x[OUT_W-1] && !o_source_y[OUT_W-1]))
        else $error("negative source position on valid sample");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");
`endif

endmodule

@@ tb/perspective_inverse_pixel_map_tb.sv @@
// Testbench for the perspective inverse pixel map: drives display pixels and
// register writes, predicts u, v, source position and valid flag with exact
// wide arithmetic and checks every beat in order. Depends on pimap_pkg.
`timescale 1ns / 100ps

module perspective_inverse_pixel_map_tb;
    import pimap_pkg::*;

    localparam int PIPE_DEPTH = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [31:0] u;
        logic [31:0] v;
        logic [31:0] sx;
        logic [31:0] sy;
        logic        ok;
    } t_coords;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [COEF_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [PIX_W-1:0] i_pixel_x = '0;
    logic [PIX_W-1:0] i_pixel_y = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [OUT_W-1:0] o_u_coord, o_v_coord, o_source_x, o_source_y;
    logic o_sample_valid;

    logic signed [COEF_W-1:0] coef_a0 = '0, coef_a1 = '0, coef_b0 = '0, coef_b1 = '0;
    logic signed [COEF_W-1:0] coef_b2 = '0, coef_c0 = '0, coef_c1 = '0;
    logic [31:0] src_dims = '0;

    t_coords expected_coords[$];
    int errors = 0;
    int idle_cycles = 0;
    int rx_wait = 0;
    bit rx_stall_on = 1'b1;

    perspective_inverse_pixel_map dut (.*);

    always #5 i_clk = ~i_clk;

    // exact ratio times scale, truncated toward zero, saturated to 32 bits
    function automatic logic [31:0] scaled_ratio(logic signed [127:0] num,
                                                 logic signed [127:0] den,
                                                 logic [127:0] scale);
        logic [127:0] q;
        logic neg;
        neg = (num < 0) != (den < 0);
        q = ((num < 0 ? -num : num) * scale) / (den < 0 ? -den : den);
        if (q == 0) return 32'd0;
        if (!neg) return (q > 128'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
        if (q > 128'h80000000) return 32'h80000000;
        return -q[31:0];
    endfunction

    function automatic logic within_unit(logic signed [127:0] num,
                                         logic signed [127:0] den);
        if (num != 0 && ((num < 0) != (den < 0))) return 1'b0;
        return (num < 0 ? -num : num) <= (den < 0 ? -den : den);
    endfunction

    function automatic t_coords map_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        t_coords r;
        logic signed [127:0] nu, nv, w, sx, sy;
        logic [127:0] wd, ht;
        r = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0};
        sx = 128'($signed({1'b0, px}));
        sy = 128'($signed({1'b0, py}));
        wd = 128'(src_dims[15:0]);
        ht = 128'(src_dims[31:16]);
        w = (128'(coef_c0) <<< 4) + 128'(coef_c1) * sx;
        if (wd == 0 || ht == 0 || w == 0) return r;
        nu = (128'(coef_a0) <<< 4) + 128'(coef_a1) * sx;
        nv = (128'(coef_b0) <<< 4) + 128'(coef_b1) * sx + 128'(coef_b2) * sy;
        r.u = scaled_ratio(nu, w, 128'd1 << 16);
        r.v = scaled_ratio(nv, w, 128'd1 << 16);
        r.sx = scaled_ratio(nu, w, wd << 8);
        r.sy = scaled_ratio(nv, w, ht << 8);
        r.ok = within_unit(nu, w) && within_unit(nv, w);
        return r;
    endfunction

    task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, bit gaps = 1);
        int gap;
        gap = gaps ? $urandom_range(0, 12) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_coords.push_back(map_pixel(px, py));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_coords.size() != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 5) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_U_BASE:   coef_a0 = data;
            REG_U_STEP_X: coef_a1 = data;
            REG_V_BASE:   coef_b0 = data;
            REG_V_STEP_X: coef_b1 = data;
            REG_V_STEP_Y: coef_b2 = data;
            REG_D_BASE:   coef_c0 = data;
            REG_D_STEP_X: coef_c1 = data;
            REG_SRC_DIMS: src_dims = data[31:0];
            default: ;
        endcase
    endtask

    task automatic load_geometry(logic [COEF_W-1:0] a0, logic [COEF_W-1:0] a1,
                                 logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b1,
                                 logic [COEF_W-1:0] b2, logic [COEF_W-1:0] c0,
                                 logic [COEF_W-1:0] c1, logic [COEF_W-1:0] dims);
        drain();
        write_reg(REG_U_BASE, a0);
        write_reg(REG_U_STEP_X, a1);
        write_reg(REG_V_BASE, b0);
        write_reg(REG_V_STEP_X, b1);
        write_reg(REG_V_STEP_Y, b2);
        write_reg(REG_D_BASE, c0);
        write_reg(REG_D_STEP_X, c1);
        write_reg(REG_SRC_DIMS, dims);
    endtask

    // plausible geometry: unit-scale coefficients with small per-pixel slopes
    function automatic logic [COEF_W-1:0] rand_coef(int frac_shift);
        logic signed [COEF_W-1:0] c;
        c = COEF_W'($signed({$urandom(), $urandom()}) >>> frac_shift);
        return c;
    endfunction

    function automatic logic [COEF_W-1:0] rand_full();
        return COEF_W'({$urandom(), $urandom()});
    endfunction

    task automatic test_reset_defaults();
        send_pixel('0, '0, 0);
        send_pixel('1, '1, 0);
    endtask

    task automatic test_directed_extremes();
        load_geometry(48'h0000_0000_0000, 48'h0000_0001_0000, 48'h0000_8000_0000,
                      48'h0, 48'h0000_0000_8000, 48'h0001_0000_0000, 48'h0,
                      {16'h0, 16'd1080, 16'd1920});
        send_pixel('0, '0, 0);
        send_pixel(17'h1FFFF, 17'h1FFFF, 0);
        send_pixel(17'h10000, 17'h00001, 0);
        send_pixel(17'h0FFFF, 17'h10000, 0);
        // unit boundaries: u exactly 1, then past it
        load_geometry(48'h0001_0000_0000, 48'h0, 48'h0, 48'h0, 48'h0,
                      48'h0001_0000_0000, 48'h0, {16'h0, 16'hFFFF, 16'hFFFF});
        send_pixel(17'd5, 17'd7, 0);
        drain();
        write_reg(REG_U_BASE, 48'h0001_0000_0001);
        send_pixel(17'd5, 17'd7, 0);
        // zero depth at px 256, sign changes around it
        load_geometry(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h8000_0000_0000,
                      48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFF0,
                      48'h0000_0000_0001, {16'h0, 16'h1, 16'h1});
        send_pixel(17'd256, 17'd0, 0);
        send_pixel(17'd255, 17'h1FFFF, 0);
        send_pixel(17'd257, 17'h1FFFF, 0);
        send_pixel(17'h1FFFF, 17'd0, 0);
        // zero width, then zero height
        drain();
        write_reg(REG_SRC_DIMS, {16'h0, 16'd10, 16'd0});
        send_pixel(17'd3, 17'd3, 0);
        drain();
        write_reg(REG_SRC_DIMS, {16'h0, 16'd0, 16'd10});
        send_pixel(17'd3, 17'd3, 0);
        // dimension write with its unused upper bits set; indexes are 3 bits, all used
        drain();
        write_reg(REG_SRC_DIMS, {16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_pixel(17'd3, 17'd3, 0);
    endtask

    task automatic test_random_frames();
        for (int f = 0; f < 12; f++) begin
            if (f % 4 == 3)
                load_geometry(rand_full(), rand_full(), rand_full(), rand_full(),
                              rand_full(), rand_full(), rand_full(), rand_full());
            else
                load_geometry(rand_coef(14), rand_coef(22), rand_coef(14), rand_coef(22),
                              rand_coef(22), rand_coef(13), rand_coef(24),
                              {16'h0, 16'($urandom_range(1, 65535)),
                               16'($urandom_range(1, 65535))});
            for (int k = 0; k < 50; k++) begin
                if (k == 25 && f == 5) drain();
                send_pixel(17'($urandom_range(0, 17'h1FFFF)),
                           17'($urandom_range(0, 17'h1FFFF)), f % 3 != 1);
            end
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            errors++;
            $display("%0t %s mismatch: expected %h actual %h", $time, name, exp, act);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if ($urandom_range(0, 199) == 0) rx_stall_on = !rx_stall_on;
            if (rx_wait > 0) begin
                rx_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            rx_wait = rx_stall_on ? $urandom_range(0, 12) : 0;
            if (expected_coords.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: expected none actual u=%h", $time,
                         o_u_coord);
            end else begin
                t_coords e;
                e = expected_coords.pop_front();
                check_field("u_coord", e.u, o_u_coord);
                check_field("v_coord", e.v, o_v_coord);
                check_field("source_x", e.sx, o_source_x);
                check_field("source_y", e.sy, o_source_y);
                check_field("sample_valid", 32'(e.ok), 32'(o_sample_valid));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_extremes();
        test_random_frames();
        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/pimap_pkg.sv
hdl/pimap_affine.sv
hdl/pimap_div.sv
hdl/perspective_inverse_pixel_map.sv
tb/perspective_inverse_pixel_map_tb.sv
